// ===== design/slp_pkg.sv =====
// Shared types and constants of the sign-error LMS predictor.
`timescale 1ns / 1ps

package slp_pkg;

  localparam int DATA_W         = 32;
  localparam int SAMPLE_W       = 24;
  localparam int TAPS_CFG_W     = 6;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  localparam int MAX_TAPS_DEF   = 32;
  localparam int FRAC_BITS_DEF  = 14;
  localparam int STEP_SHIFT_DEF = 5;

  localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 6'd32;

  // Register index, taken from paddr[2].
  localparam logic REG_TAPS_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    SIGN_ZERO,
    SIGN_POS,
    SIGN_NEG
  } sign_t;

  typedef struct packed {
    logic  clear;
    logic  mul_go;
    logic  upd_mode;
    sign_t sign;
  } alu_ctrl_t;

endpackage

// ===== design/slp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module slp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/slp_alu.sv =====
// Shared multiplier with accumulator and weight-update adder.
`timescale 1ns / 1ps

module slp_alu #(
  parameter int FRAC_BITS  = slp_pkg::FRAC_BITS_DEF,
  parameter int STEP_SHIFT = slp_pkg::STEP_SHIFT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  slp_pkg::alu_ctrl_t         ctrl,
  input  logic [slp_pkg::DATA_W-1:0] weight,
  input  logic [slp_pkg::DATA_W-1:0] history,
  output logic [slp_pkg::DATA_W-1:0] prediction,
  output logic [slp_pkg::DATA_W-1:0] new_weight,
  output logic                       prod_valid
);

  localparam logic [slp_pkg::DATA_W-1:0] HALF  = slp_pkg::DATA_W'(1) << (FRAC_BITS - 1);
  localparam logic [slp_pkg::DATA_W-1:0] ROUND = slp_pkg::DATA_W'(1) << (STEP_SHIFT - 1);

  logic [slp_pkg::DATA_W-1:0] sign_word;
  logic [slp_pkg::DATA_W-1:0] mul_a;
  logic [slp_pkg::DATA_W-1:0] product;
  logic [slp_pkg::DATA_W-1:0] prod_q;
  logic [slp_pkg::DATA_W-1:0] weight_q;
  logic [slp_pkg::DATA_W-1:0] acc;
  logic [slp_pkg::DATA_W-1:0] step_sum;

  always_comb begin
    case (ctrl.sign)
      slp_pkg::SIGN_POS: sign_word = slp_pkg::DATA_W'(1);
      slp_pkg::SIGN_NEG: sign_word = '1;
      default:           sign_word = '0;
    endcase
  end

  // The multiplier serves both passes: weight times history for the
  // prediction, and sign times history for the update.
  assign mul_a   = ctrl.upd_mode ? sign_word : weight;
  assign product = mul_a * history;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.mul_go;
    end
    prod_q   <= product;
    weight_q <= weight;
    if (ctrl.clear) begin
      acc <= HALF;
    end else if (prod_valid && !ctrl.upd_mode) begin
      acc <= acc + prod_q;
    end
  end

  assign step_sum   = prod_q + ROUND;
  assign new_weight = weight_q + slp_pkg::DATA_W'($signed(step_sum) >>> STEP_SHIFT);
  assign prediction = slp_pkg::DATA_W'($signed(acc) >>> FRAC_BITS);

endmodule

// ===== design/sign_error_lms_predictor.sv =====
// Top level of the sign-error LMS adaptive predictor.
`timescale 1ns / 1ps

// Sign-error LMS adaptive predictor. Each accepted input transaction carries
// one 24-bit audio sample and a restart flag; the block answers with one
// 32-bit residual, the sample minus the rounded weighted sum of the last
// T = min(taps_in_use, MAX_TAPS) samples, and then nudges each of those T
// weights by the sign of the residual times the matching past sample.
// A single 32x32 multiplier does all the work under a small sequencer: one
// pass over the taps builds the prediction, a second pass updates the
// weights, and a final history step stores the new sample in the ring.
// Each pass issues a read for every tap in turn and then drains the RAM read
// and multiplier pipeline. in_stall stays high from acceptance until the
// block returns to idle. The result sits in an output register, so the next
// sample is taken while a residual still waits on out_stall; a residual
// still held there when the next transaction completes keeps the block in
// its completion step until the receiver takes it.
// Weights and history live in two RAMs; per-entry valid flags make a reset
// or a restart take effect at once, with no clearing pass. Write
// taps_in_use (register 0, byte address 0, low six bits) only while the
// block is idle; values above MAX_TAPS act as MAX_TAPS.
module sign_error_lms_predictor #(
  parameter int MAX_TAPS   = slp_pkg::MAX_TAPS_DEF,
  parameter int FRAC_BITS  = slp_pkg::FRAC_BITS_DEF,
  parameter int STEP_SHIFT = slp_pkg::STEP_SHIFT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [slp_pkg::SAMPLE_W-1:0] sample,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [slp_pkg::DATA_W-1:0]  residual,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [slp_pkg::PADDR_W-1:0]        paddr,
  input  logic [slp_pkg::PDATA_W-1:0]        pwdata,
  output logic [slp_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int DW    = slp_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_UPD,
    ST_HIST,
    ST_DONE
  } state_t;

  state_t state;

  logic [slp_pkg::TAPS_CFG_W-1:0] taps_in_use;
  logic [CNT_W-1:0]               taps_eff;
  logic [CNT_W-1:0]               cnt;
  logic [AW-1:0]                  idx;
  logic [AW:0]                    phys_sum;
  logic [AW-1:0]                  phys;
  logic [AW-1:0]                  head;
  logic [AW-1:0]                  head_dec;
  logic [AW-1:0]                  idx_d1;
  logic [AW-1:0]                  idx_d2;
  logic [MAX_TAPS-1:0]            w_vld;
  logic [MAX_TAPS-1:0]            h_vld;
  logic                           w_vld_q;
  logic                           h_vld_q;
  logic                           rd_v;
  logic                           issue;
  logic                           drained;
  logic                           accept;
  logic                           cfg_wr;
  logic [slp_pkg::SAMPLE_W-1:0]   sample_q;
  logic [DW-1:0]                  sample_ext;
  logic [DW-1:0]                  resid_q;
  logic [DW-1:0]                  w_rdata;
  logic [DW-1:0]                  h_rdata;
  logic [DW-1:0]                  w_op;
  logic [DW-1:0]                  h_op;
  logic [DW-1:0]                  prediction;
  logic [DW-1:0]                  new_weight;
  logic                           prod_valid;
  logic                           w_we;
  logic                           h_we;
  slp_pkg::alu_ctrl_t             alu_ctrl;
  slp_pkg::sign_t                 resid_sign;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == slp_pkg::REG_TAPS_IN_USE);

  always_comb begin
    prdata = '0;
    if (paddr[2] == slp_pkg::REG_TAPS_IN_USE) begin
      prdata = slp_pkg::PDATA_W'(taps_in_use);
    end
  end

  // Tap counts above the stored depth saturate.
  assign taps_eff = (32'(taps_in_use) > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                       : CNT_W'(taps_in_use);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);

  // Sequencer: one tap index per cycle during each pass.
  assign issue   = ((state == ST_MAC) || (state == ST_UPD)) && (cnt < taps_eff);
  assign drained = !issue && !rd_v && !prod_valid;
  assign idx     = cnt[AW-1:0];

  // History is a ring: tap i sits at head + i, wrapped at the depth.
  assign phys_sum = {1'b0, head} + {1'b0, idx};
  assign phys     = (phys_sum >= (AW + 1)'(MAX_TAPS)) ? AW'(phys_sum - (AW + 1)'(MAX_TAPS))
                                                     : phys_sum[AW-1:0];
  assign head_dec = (head == '0) ? AW'(MAX_TAPS - 1) : head - AW'(1);

  assign sample_ext = {{(DW - slp_pkg::SAMPLE_W){sample_q[slp_pkg::SAMPLE_W-1]}}, sample_q};

  always_comb begin
    if (resid_q == '0) begin
      resid_sign = slp_pkg::SIGN_ZERO;
    end else if (resid_q[DW-1]) begin
      resid_sign = slp_pkg::SIGN_NEG;
    end else begin
      resid_sign = slp_pkg::SIGN_POS;
    end
  end

  always_comb begin
    alu_ctrl.clear    = accept;
    alu_ctrl.mul_go   = rd_v;
    alu_ctrl.upd_mode = (state == ST_UPD);
    alu_ctrl.sign     = resid_sign;
  end

  // Entries never written since reset or restart read as zero.
  assign w_op = w_vld_q ? w_rdata : '0;
  assign h_op = h_vld_q ? h_rdata : '0;

  assign w_we = prod_valid && (state == ST_UPD);
  assign h_we = (state == ST_HIST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      taps_in_use <= slp_pkg::TAPS_RESET;
      cnt         <= '0;
      head        <= '0;
      w_vld       <= '0;
      h_vld       <= '0;
      rd_v        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        taps_in_use <= pwdata[slp_pkg::TAPS_CFG_W-1:0];
      end
      rd_v <= issue;
      if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
      // In the completion step the result register is reloaded below instead.
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      if (w_we) begin
        w_vld[idx_d2] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt   <= '0;
            state <= ST_MAC;
            if (restart) begin
              w_vld <= '0;
              h_vld <= '0;
            end
          end
        end
        ST_MAC: begin
          if (drained) begin
            cnt   <= '0;
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (drained) begin
            state <= ST_HIST;
          end
        end
        ST_HIST: begin
          head           <= head_dec;
          h_vld[head_dec] <= 1'b1;
          state          <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    if (accept) begin
      sample_q <= sample;
    end
    if ((state == ST_MAC) && drained) begin
      resid_q <= sample_ext - prediction;
    end
    if ((state == ST_DONE) && (!out_valid || !out_stall)) begin
      residual <= resid_q;
    end
    w_vld_q <= w_vld[idx];
    h_vld_q <= h_vld[phys];
    idx_d1  <= idx;
    idx_d2  <= idx_d1;
  end

  slp_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_TAPS),
    .AW    (AW)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (idx_d2),
    .wdata (new_weight),
    .raddr (idx),
    .rdata (w_rdata)
  );

  slp_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_TAPS),
    .AW    (AW)
  ) u_history_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (head_dec),
    .wdata (sample_ext),
    .raddr (phys),
    .rdata (h_rdata)
  );

  slp_alu #(
    .FRAC_BITS  (FRAC_BITS),
    .STEP_SHIFT (STEP_SHIFT)
  ) u_alu (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (alu_ctrl),
    .weight     (w_op),
    .history    (h_op),
    .prediction (prediction),
    .new_weight (new_weight),
    .prod_valid (prod_valid)
  );

`ifndef SYNTHESIS
  // A transaction that is taken closes the input side until it completes.
  assert property (@(posedge clk) disable iff (rst) accept |=> in_stall)
    else $error("input taken again while busy");

  // Weight writes trail the read pipeline and stay within the taps in use.
  assert property (@(posedge clk) disable iff (rst) w_we |-> (32'(idx_d2) < 32'(taps_eff)))
    else $error("weight write beyond taps in use");

  // The update pass starts from tap zero with an empty multiplier pipeline.
  assert property (@(posedge clk) disable iff (rst)
    ((state == ST_UPD) && ($past(state) == ST_MAC)) |-> ((cnt == '0) && !rd_v && !prod_valid))
    else $error("update pass entered with pipeline busy");

  // A new residual appears only from the final sequencer step.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside completion");
`endif

endmodule

// ===== tb/tb_sign_error_lms_predictor.sv =====
// Self-checking testbench for the sign-error LMS adaptive predictor.
`timescale 1ns / 1ps

module tb_sign_error_lms_predictor;

  localparam int DATA_W     = slp_pkg::DATA_W;
  localparam int SAMPLE_W   = slp_pkg::SAMPLE_W;
  localparam int TAPS_CFG_W = slp_pkg::TAPS_CFG_W;
  localparam int PADDR_W    = slp_pkg::PADDR_W;
  localparam int PDATA_W    = slp_pkg::PDATA_W;
  localparam logic REG_TAPS_IN_USE = slp_pkg::REG_TAPS_IN_USE;
  localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = slp_pkg::TAPS_RESET;

  localparam int N_TAPS       = slp_pkg::MAX_TAPS_DEF;
  localparam int FRAC         = slp_pkg::FRAC_BITS_DEF;
  localparam int STEP         = slp_pkg::STEP_SHIFT_DEF;
  localparam int TOTAL_ITEMS  = 950;
  localparam int TAIL_ITEMS   = 120;   // last stretch of the run, no idling at all
  localparam int HOLD_CYCLES  = 600;   // long receiver hold-off that backs up the block
  localparam int QUIET_LIMIT  = 4000;  // cycles without any transaction before giving up
  localparam int DRAIN_CYCLES = 100;
  localparam int N_DIRECTED   = 20;

  // Byte addresses of the register map. Only index 0 exists; index 1 must be ignored.
  localparam logic [PADDR_W-1:0] ADDR_TAPS   = {REG_TAPS_IN_USE, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNUSED = {~REG_TAPS_IN_USE, 2'b00};

  // One row of the directed table. When typed is set, want is the residual read
  // straight off the behavior (restart or fresh reset means an all-zero filter,
  // so the residual is the sample itself); otherwise the predictor supplies it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                rs;
    logic                typed;
    logic [DATA_W-1:0]   want;
  } directed_row_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [DATA_W-1:0]   residual;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [PADDR_W-1:0]         paddr;
  logic [PDATA_W-1:0]         pwdata;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  // Shadow copy of the filter state and the tap-count register.
  logic [DATA_W-1:0]     lms_weight [N_TAPS];
  logic [DATA_W-1:0]     lms_hist   [N_TAPS];
  logic [TAPS_CFG_W-1:0] taps_cfg;

  logic [DATA_W-1:0] expected_residuals [$];
  directed_row_t     directed_rows [N_DIRECTED];

  int mismatches;
  int quiet_cycles;
  int items_sent;
  bit idle_on;
  bit hold_req;

  // State of the smooth, tone-like sample generator.
  int tone_pos;
  int tone_vel;

  sign_error_lms_predictor DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .residual  (residual),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Works out the residual of one sample and advances the shadow filter.
  // Everything is 32-bit wrapping arithmetic. The prediction is the rounded,
  // arithmetically shifted dot product of the weights in use with the history.
  // Each weight in use then moves by the sign of the residual times its history
  // entry, rounded and shifted down by the step size; a zero residual leaves only
  // the rounding term, which shifts out. The history shifts on every sample,
  // even with zero taps, so it always holds the most recent MAX_TAPS samples.
  function automatic logic [DATA_W-1:0] predict_residual(input logic [SAMPLE_W-1:0] smp,
                                                         input logic rs);
    logic [DATA_W-1:0]        x;
    logic [DATA_W-1:0]        acc;
    logic [DATA_W-1:0]        res;
    logic [DATA_W-1:0]        nudge;
    logic signed [DATA_W-1:0] pred;
    logic signed [DATA_W-1:0] delta;
    int                       n;
    int                       i;
    x = {{(DATA_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
    if (rs) begin
      for (i = 0; i < N_TAPS; i++) begin
        lms_weight[i] = '0;
        lms_hist[i]   = '0;
      end
    end
    // A tap count above the filter length acts as the full length.
    n = (int'(taps_cfg) > N_TAPS) ? N_TAPS : int'(taps_cfg);
    acc = 32'd1 << (FRAC - 1);
    for (i = 0; i < n; i++) begin
      acc = acc + lms_weight[i] * lms_hist[i];
    end
    pred = $signed(acc) >>> FRAC;
    res  = x - pred;
    for (i = 0; i < n; i++) begin
      if (res == '0) begin
        nudge = '0;
      end else if (res[DATA_W-1]) begin
        nudge = -lms_hist[i];
      end else begin
        nudge = lms_hist[i];
      end
      nudge = nudge + (32'd1 << (STEP - 1));
      delta = $signed(nudge) >>> STEP;
      lms_weight[i] = lms_weight[i] + delta;
    end
    for (i = N_TAPS - 1; i > 0; i--) begin
      lms_hist[i] = lms_hist[i-1];
    end
    lms_hist[0] = x;
    return res;
  endfunction

  // Random sample source. Half the samples follow a smooth, bouncing trajectory
  // so the filter really adapts and its weights grow; the rest are quiet noise,
  // full-range values that toggle every bit, and rail-to-rail extremes that
  // drive the accumulator into wraparound.
  function automatic logic [SAMPLE_W-1:0] draw_sample();
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      tone_vel = tone_vel + int'($urandom_range(0, 4000)) - 2000;
      if (tone_vel > 300000) tone_vel = 300000;
      if (tone_vel < -300000) tone_vel = -300000;
      tone_pos = tone_pos + tone_vel;
      if (tone_pos > 8388607) begin
        tone_pos = 8388607;
        tone_vel = -tone_vel;
      end else if (tone_pos < -8388608) begin
        tone_pos = -8388608;
        tone_vel = -tone_vel;
      end
      v = tone_pos;
    end else if (pick < 7) begin
      v = int'($urandom_range(0, 512)) - 256;
    end else if (pick < 9) begin
      v = $urandom();
    end else begin
      v = ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
    end
    return v[SAMPLE_W-1:0];
  endfunction

  // Tap counts walked by the random phases: the corner values come first
  // (zero taps, one tap, the full length, the largest 6-bit value and just
  // past the full length), then 2, 31 and 16, then random counts across the whole register.
  function automatic logic [TAPS_CFG_W-1:0] taps_for_phase(input int p);
    case (p)
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      4: return 6'd33;
      5: return 6'd2;
      6: return 6'd31;
      7: return 6'd16;
      default: return TAPS_CFG_W'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic void report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                          input logic [DATA_W-1:0] got);
    if (mismatches < 10) begin
      $display("%s mismatch: expected %h, got %h", what, want, got);
    end
    mismatches++;
  endfunction

  // Register write: setup cycle, then access cycle; the register takes the
  // value at the rising edge where the access phase completes.
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_TAPS_IN_USE) begin
      taps_cfg = data[TAPS_CFG_W-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sets a new tap count. A write to the unused index goes first with random
  // data and must not disturb anything; the real write carries random upper
  // bits that the block has to drop. The readback checks the stored count.
  task automatic set_taps(input logic [TAPS_CFG_W-1:0] taps);
    logic [PDATA_W-1:0] data;
    logic [PDATA_W-1:0] readback;
    apb_write(ADDR_UNUSED, $urandom());
    data = $urandom();
    data[TAPS_CFG_W-1:0] = taps;
    apb_write(ADDR_TAPS, data);
    apb_read(ADDR_TAPS, readback);
    if (readback[TAPS_CFG_W-1:0] !== taps) begin
      report_mismatch("taps_in_use readback", {{(PDATA_W-TAPS_CFG_W){1'b0}}, taps}, readback);
    end
  endtask

  // Offers one sample transaction and records its expected residual once the
  // block takes it. The valid line is left high on purpose: the next call
  // either replaces the payload at the following falling edge or drops valid
  // for an idle burst, so a back-to-back stream never glitches valid low.
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic rs,
                             input logic typed, input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] predicted;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= smp;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    // The predictor runs for every transaction so its state stays in step,
    // even when the table already gives the answer.
    predicted = predict_residual(smp, rs);
    expected_residuals.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // The block is idle once every residual has been taken and it no longer
  // stalls its input; only then may the tap count change.
  task automatic wait_until_idle();
    do @(posedge clk); while (expected_residuals.size() != 0 || in_stall);
  endtask

  // Receiver side. It stalls in random bursts while idling is enabled, and on
  // request holds off for one long stretch so the sender backs the block up.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker: every residual transaction must match the oldest
  // expectation; a residual with nothing outstanding is a failure as well.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_residuals.size() == 0) begin
        report_mismatch("unexpected residual", '0, residual);
      end else begin
        logic [DATA_W-1:0] want;
        want = expected_residuals.pop_front();
        if (residual !== want) begin
          report_mismatch("residual", want, residual);
        end
      end
    end
  end

  // Watchdog: any transaction on any port counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_sign_error_lms_predictor: done, errors");
      $finish;
    end
  end

  initial begin
    int phase;
    int n_items;
    int k;

    // Every input starts at a known value.
    rst        = 1'b1;
    in_valid   = 1'b0;
    sample     = '0;
    restart    = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    mismatches = 0;
    items_sent = 0;
    tone_pos   = 0;
    tone_vel   = 0;
    taps_cfg   = TAPS_RESET;
    for (k = 0; k < N_TAPS; k++) begin
      lms_weight[k] = '0;
      lms_hist[k]   = '0;
    end

    // Directed rows, at the reset tap count. They cover both rails of the
    // sample, alternating rails that blow the weights up until the
    // accumulator wraps, restarts that land on a rail or on zero, a zero
    // residual right after a restart, and alternating bit patterns.
    directed_rows = '{
      '{24'h7FFFFF, 1'b0, 1'b1, 32'h007FFFFF},
      '{24'h800000, 1'b0, 1'b0, 32'h0},
      '{24'h7FFFFF, 1'b0, 1'b0, 32'h0},
      '{24'h800000, 1'b0, 1'b0, 32'h0},
      '{24'h7FFFFF, 1'b0, 1'b0, 32'h0},
      '{24'h800000, 1'b0, 1'b0, 32'h0},
      '{24'hFFFFFF, 1'b0, 1'b0, 32'h0},
      '{24'h000001, 1'b0, 1'b0, 32'h0},
      '{24'h7FFFFF, 1'b1, 1'b1, 32'h007FFFFF},
      '{24'h800000, 1'b1, 1'b1, 32'hFF800000},
      '{24'h000000, 1'b1, 1'b1, 32'h00000000},
      '{24'h000000, 1'b0, 1'b0, 32'h0},
      '{24'h555555, 1'b0, 1'b0, 32'h0},
      '{24'hAAAAAA, 1'b0, 1'b0, 32'h0},
      '{24'h0003E8, 1'b0, 1'b0, 32'h0},
      '{24'h0007D0, 1'b0, 1'b0, 32'h0},
      '{24'h000BB8, 1'b0, 1'b0, 32'h0},
      '{24'hFFEC78, 1'b0, 1'b0, 32'h0},
      '{24'h01E240, 1'b0, 1'b0, 32'h0},
      '{24'hFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF}
    };

    // Synchronous reset, asserted once at the start and never asserted again.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (k = 0; k < N_DIRECTED; k++) begin
      send_sample(directed_rows[k].smp, directed_rows[k].rs,
                  directed_rows[k].typed, directed_rows[k].want);
    end

    // Random phases. Each one waits for the block to go idle, picks a new tap
    // count and then streams samples. Most phases carry on from the previous
    // history and weights, so tap-count changes mid-stream get exercised; a
    // restart shows up now and then. Some phases run with no idling on
    // either side, and the tail of the run has none at all.
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      drop_valid();
      wait_until_idle();
      set_taps(taps_for_phase(phase));
      if (items_sent >= TOTAL_ITEMS - TAIL_ITEMS) begin
        idle_on = 1'b0;
      end else begin
        idle_on = ($urandom_range(0, 3) != 0);
      end
      // One long receiver hold-off while the sender keeps offering samples.
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      n_items = $urandom_range(40, 80);
      for (k = 0; k < n_items && items_sent < TOTAL_ITEMS; k++) begin
        send_sample(draw_sample(), ($urandom_range(0, 49) == 0), 1'b0, '0);
      end
      phase++;
    end

    // Drain: wait for every residual, then let the block settle a little.
    drop_valid();
    do @(posedge clk); while (expected_residuals.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_residuals.size() == 0) begin
      $display("tb_sign_error_lms_predictor: done, clean");
    end else begin
      $display("tb_sign_error_lms_predictor: done, errors");
    end
    $finish;
  end

endmodule
